// ===== hdl/xcbc_pkg.sv =====
// Package for the XTEA-CBC block decryptor: payload structs, key type,
// register map codes and XTEA constants. No dependencies.
`timescale 1ns / 1ps

package xcbc_pkg;

  localparam int unsigned ROUND_COUNT_DEF = 32;
  localparam logic [31:0] XTEA_DELTA     = 32'h9E37_79B9;
  // Starting sum for the default round count (delta times 32).
  localparam logic [31:0] XTEA_SUM_32    = 32'hC6EF_3720;

  localparam int unsigned CFG_ADDR_W = 5;

  // Register indexes (byte address is four times the index).
  localparam logic [2:0] REG_KEY_WORD0 = 3'd0;
  localparam logic [2:0] REG_KEY_WORD1 = 3'd1;
  localparam logic [2:0] REG_KEY_WORD2 = 3'd2;
  localparam logic [2:0] REG_KEY_WORD3 = 3'd3;
  localparam logic [2:0] REG_IV_WORD0  = 3'd4;
  localparam logic [2:0] REG_IV_WORD1  = 3'd5;

  typedef logic [3:0][31:0] key_t;

  typedef struct packed {
    logic [31:0] cipher_word0;
    logic [31:0] cipher_word1;
    logic        start_chain;
  } cipher_in_t;

  typedef struct packed {
    logic [31:0] plain_word0;
    logic [31:0] plain_word1;
  } plain_out_t;

  // Data handed from cell to cell. Each cell updates q from p and swaps them.
  typedef struct packed {
    logic [31:0] p;
    logic [31:0] q;
    logic [63:0] chain;
  } stage_t;

endpackage

// ===== hdl/xcbc_round_cell.sv =====
// One XTEA decryption half-round cell of the pipeline.
// Depends on xcbc_pkg for the stage and key types.
`timescale 1ns / 1ps

module xcbc_round_cell
  import xcbc_pkg::*;
#(
  parameter logic [31:0] SUM     = XTEA_SUM_32,
  parameter logic [1:0]  KEY_SEL = 2'd0
) (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   adv,
  input  key_t   key,
  input  logic   valid_i,
  input  stage_t data_i,
  output logic   valid_o,
  output stage_t data_o
);

  logic [31:0] rk;
  logic [31:0] mix;
  logic        valid_r;
  logic        valid_nxt;
  stage_t      data_r;
  stage_t      data_nxt;

  // The round key depends only on the key registers and the fixed sum, so it
  // settles in parallel with the shift terms of the mix.
  assign rk = SUM + key[KEY_SEL];

  assign mix = ((((data_i.p << 4) ^ (data_i.p >> 5)) + data_i.p) ^ rk);

  always_comb begin
    valid_nxt      = valid_r;
    data_nxt       = data_r;
    if (adv) begin
      valid_nxt      = valid_i;
      data_nxt.p     = data_i.q - mix;
      data_nxt.q     = data_i.p;
      data_nxt.chain = data_i.chain;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  assign valid_o = valid_r;
  assign data_o  = data_r;

endmodule

// ===== hdl/xtea_cbc_block_decrypt_top.sv =====
// XTEA-CBC block decryptor, top level: configuration registers, chaining
// register, the row of half-round cells and the output register.
// Depends on xcbc_pkg and xcbc_round_cell.
`timescale 1ns / 1ps

// The block takes one 64-bit ciphertext item per cycle while in_ready is high
// and returns one plaintext item per ciphertext item, in order. An item is
// captured by the first of 2*ROUND_COUNT half-round cells at the edge that
// accepts it and then moves one register per cycle through the cells and the
// output register while the line advances. The whole line advances together:
// while a result waits at the output with out_ready low, the line holds and
// in_ready is low. The key and IV registers must only be written while
// no item is in flight; the chaining value is taken when an item enters.

module xtea_cbc_block_decrypt_top
  import xcbc_pkg::*;
#(
  parameter int unsigned ROUND_COUNT = ROUND_COUNT_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  cipher_in_t            in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output plain_out_t            out_data,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]           cfg_pwdata,
  output logic [31:0]           cfg_prdata,
  output logic                  cfg_pready
);

  localparam int unsigned STAGES = 2 * ROUND_COUNT;

  key_t        key_r;
  key_t        key_nxt;
  logic [31:0] iv0_r;
  logic [31:0] iv0_nxt;
  logic [31:0] iv1_r;
  logic [31:0] iv1_nxt;
  logic [63:0] chain_r;
  logic [63:0] chain_nxt;
  logic        out_valid_r;
  logic        out_valid_nxt;
  plain_out_t  out_data_r;
  plain_out_t  out_data_nxt;

  logic        adv;
  logic        in_acc;
  logic        cfg_wr;
  logic [2:0]  cfg_idx;

  logic [STAGES:0] vld;
  stage_t          dat [STAGES+1];

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite;
  assign cfg_idx    = cfg_paddr[CFG_ADDR_W-1:2];

  always_comb begin
    key_nxt = key_r;
    iv0_nxt = iv0_r;
    iv1_nxt = iv1_r;
    if (cfg_wr) begin
      case (cfg_idx)
        REG_KEY_WORD0: key_nxt[0] = cfg_pwdata;
        REG_KEY_WORD1: key_nxt[1] = cfg_pwdata;
        REG_KEY_WORD2: key_nxt[2] = cfg_pwdata;
        REG_KEY_WORD3: key_nxt[3] = cfg_pwdata;
        REG_IV_WORD0:  iv0_nxt    = cfg_pwdata;
        REG_IV_WORD1:  iv1_nxt    = cfg_pwdata;
        default:       ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_KEY_WORD0: cfg_prdata = key_r[0];
      REG_KEY_WORD1: cfg_prdata = key_r[1];
      REG_KEY_WORD2: cfg_prdata = key_r[2];
      REG_KEY_WORD3: cfg_prdata = key_r[3];
      REG_IV_WORD0:  cfg_prdata = iv0_r;
      REG_IV_WORD1:  cfg_prdata = iv1_r;
      default:       cfg_prdata = '0;
    endcase
  end

  assign adv      = ~out_valid_r | out_ready;
  assign in_ready = adv;
  assign in_acc   = in_valid & adv;

  // Entry point of the line: the chaining value is fixed here per item.
  always_comb begin
    vld[0]       = in_valid;
    dat[0].p     = in_data.cipher_word0;
    dat[0].q     = in_data.cipher_word1;
    dat[0].chain = in_data.start_chain ? {iv1_r, iv0_r} : chain_r;
    chain_nxt    = in_acc ? {in_data.cipher_word1, in_data.cipher_word0} : chain_r;
  end

  for (genvar j = 0; j < STAGES; j++) begin : g_cell
    localparam logic [31:0] SUM_J =
      32'(64'(XTEA_DELTA) * 64'(ROUND_COUNT - (j + 1) / 2));
    localparam logic [1:0] SEL_J = (j % 2 == 1) ? SUM_J[1:0] : SUM_J[12:11];

    xcbc_round_cell #(
      .SUM     (SUM_J),
      .KEY_SEL (SEL_J)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .adv     (adv),
      .key     (key_r),
      .valid_i (vld[j]),
      .data_i  (dat[j]),
      .valid_o (vld[j+1]),
      .data_o  (dat[j+1])
    );
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (adv) begin
      out_valid_nxt            = vld[STAGES];
      out_data_nxt.plain_word0 = dat[STAGES].p ^ dat[STAGES].chain[31:0];
      out_data_nxt.plain_word1 = dat[STAGES].q ^ dat[STAGES].chain[63:32];
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    if (!rst_n) begin
      key_r       <= '0;
      iv0_r       <= '0;
      iv1_r       <= '0;
      chain_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      key_r       <= key_nxt;
      iv0_r       <= iv0_nxt;
      iv1_r       <= iv1_nxt;
      chain_r     <= chain_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
